@@ hdl/i2a_pkg.sv @@
package i2a_pkg;

  // field widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;

  // ascii codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  // control sequence of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGITS
  } state_e;

endpackage

@@ hdl/i2a_dabble.sv @@
module i2a_dabble (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [i2a_pkg::VALUE_W-1:0]    mag_i,
  output logic                           done_o,
  output logic [i2a_pkg::BCD_W-1:0]      bcd_o
);
  import i2a_pkg::*;

  logic [VALUE_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_adj;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // one magnitude bit moves into the digit register per cycle
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      mag_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[VALUE_W-2:0], 1'b0};
      bcd_d = {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // data shift registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ hdl/int32_to_decimal_ascii_top.sv @@
// signed 32-bit integer to decimal ascii text, one character per output item
// each number goes through the 32-step bit-serial shift-and-add-three conversion,
// a leading-zero strip, then character emission, which output stalls can hold
// one number at a time; the next input item is taken once the last character is loaded
// asynchronous active-low reset clears the control state; ready right after reset
module int32_to_decimal_ascii_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // fields from bit 0: value[31:0]
  input  logic [31:0]                    s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // fields from bit 0: character[6:0], zero pad[7]
  output logic [7:0]                     m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import i2a_pkg::*;

  state_e             state_q, state_d;
  logic               neg_q, neg_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               ovalid_q, ovalid_d;
  logic [CHAR_W-1:0]  ochar_q, ochar_d;
  logic               olast_q, olast_d;
  logic               in_fire;
  logic               out_free;
  logic [VALUE_W-1:0] mag;
  logic               conv_done;
  logic [BCD_W-1:0]   conv_bcd;
  logic [3:0]         top_digit;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !ovalid_q || m_axis_tready_i;
  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // unsigned magnitude, so the most negative value stays correct
  assign mag = s_axis_tdata_i[VALUE_W-1] ? (~s_axis_tdata_i + 32'd1) : s_axis_tdata_i;

  i2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .mag_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // sequencer: convert, strip leading zeros, emit the sign when negative, then the digits
  always_comb begin
    state_d         = state_q;
    neg_d           = neg_q;
    bcd_d           = bcd_q;
    cnt_d           = cnt_q;
    ovalid_d        = ovalid_q;
    ochar_d         = ochar_q;
    olast_d         = olast_q;
    s_axis_tready_o = 1'b0;
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          neg_d   = s_axis_tdata_i[VALUE_W-1];
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          bcd_d   = conv_bcd;
          cnt_d   = 4'(DIGITS);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && cnt_q > 4'd1) begin
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          cnt_d = cnt_q - 4'd1;
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_DIGITS;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = ASCII_MINUS;
          olast_d  = 1'b0;
          state_d  = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = ASCII_ZERO + {3'd0, top_digit};
          olast_d  = (cnt_q == 4'd1);
          bcd_d    = {bcd_q[BCD_W-5:0], 4'd0};
          cnt_d    = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    bcd_q   <= bcd_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {1'b0, ochar_q};
  assign m_axis_tlast_o  = olast_q;

endmodule

@@ dv/tb_int32_to_decimal_ascii_top.sv @@
`timescale 1ns / 100ps

module tb_int32_to_decimal_ascii_top;

  localparam logic [6:0] CHAR_ZERO   = 7'd48;
  localparam logic [6:0] CHAR_MINUS  = 7'd45;
  localparam int unsigned RANDOM_NUMBERS = 400;
  localparam int unsigned SEGMENT_LEN    = 40;
  localparam int unsigned MAX_IDLE       = 6;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned CYCLE_LIMIT    = 600000;

  // expected text of every accepted number, one entry per character
  class decimal_text_board;
    typedef struct {
      logic [6:0] char_code;
      logic       last;
    } text_char_t;

    text_char_t expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    local function void push_char(logic [6:0] code, logic last);
      text_char_t c;
      c.char_code = code;
      c.last      = last;
      expected_chars = {expected_chars, c};
    endfunction

    // decimal text of a signed 32-bit number, magnitude taken unsigned
    function void note_value(logic [31:0] value);
      logic [31:0] mag;
      logic [3:0]  digits[$];
      bit          neg;
      neg = value[31];
      mag = neg ? (~value + 32'd1) : value;
      if (mag == 32'd0) begin
        push_char(CHAR_ZERO, 1'b1);
        return;
      end
      while (mag != 32'd0) begin
        digits.push_front(4'(mag % 32'd10));
        mag = mag / 32'd10;
      end
      if (neg) begin
        push_char(CHAR_MINUS, 1'b0);
      end
      foreach (digits[i]) begin
        push_char(CHAR_ZERO + 7'(digits[i]), i == digits.size() - 1);
      end
    endfunction

    function void check_char(logic [7:0] tdata, logic tlast);
      text_char_t exp_c;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %0d (last %0d)", tdata[6:0], tlast);
        mismatches++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (tdata[6:0] !== exp_c.char_code) begin
        $error("character: expected %0d, got %0d", exp_c.char_code, tdata[6:0]);
        mismatches++;
      end
      if (tlast !== exp_c.last) begin
        $error("last: expected %0d, got %0d", exp_c.last, tlast);
        mismatches++;
      end
      if (tdata[7] !== 1'b0) begin
        $error("tdata pad: expected 0, got %0d", tdata[7]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;

  decimal_text_board text_board;
  bit                calm = 1'b0;
  int unsigned       cycle_count = 0;

  int32_to_decimal_ascii_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // offer one number, with an optional gap first, and wait until it is taken
  task automatic send_number(logic [31:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= value;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    text_board.note_value(value);
  endtask

  // random number: full-range bits, digit-count classes, decade edges, small values
  function automatic logic [31:0] random_number();
    longint lo;
    longint hi;
    longint mag;
    longint p10;
    int unsigned nd;
    bit neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        nd = $urandom_range(1, 10);
        p10 = 1;
        repeat (nd - 1) p10 = p10 * 10;
        lo = (nd == 1) ? 0 : p10;
        hi = p10 * 10 - 1;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag = lo + longint'($urandom_range(0, int'(hi - lo)));
      end
      2: begin
        nd = $urandom_range(0, 9);
        p10 = 1;
        repeat (nd) p10 = p10 * 10;
        mag = p10 + longint'($urandom_range(0, 2)) - 1;
      end
      default: mag = $urandom_range(0, 20);
    endcase
    if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  // output side: random stalls, check each character as it is taken
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
      text_board.check_char(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] corner_values[$];
    text_board = new();
    corner_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
                      32'd99, 32'd100, -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0001, 32'd999999999, 32'd1000000000, -32'sd999999999,
                      -32'sd1000000000, 32'd123456789, -32'sd123456789,
                      32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_values[i]) send_number(corner_values[i]);

    // random part, in stretches that each run with or without idling, chosen at random
    for (int unsigned n = 0; n < RANDOM_NUMBERS; n++) begin
      if (n % SEGMENT_LEN == 0) calm = ($urandom_range(0, 2) == 0);
      send_number(random_number());
    end
    s_axis_tvalid_i <= 1'b0;
    calm = 1'b0;

    while (text_board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (text_board.mismatches == 0 && text_board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
